>>> hdl/vapq_pkg.sv
package vapq_pkg;

	// Default ring depth and register reset values.
	localparam int QUEUE_DEPTH_DEF = 256;
	localparam logic [19:0] LEAD_RST = 20'd2700;
	localparam logic [23:0] LATE_RST = 24'd45000;
	localparam logic [25:0] DISCONT_RST = 26'd900000;
	localparam logic [5:0] MAX_DEC_RST = 6'd2;
	localparam logic [5:0] MAX_POPS_RST = 6'd32;
	localparam logic [5:0] MAX_RES = 6'd32;

	// Register map, one register per 32-bit word.
	typedef enum logic [2:0] {
		REG_LEAD = 3'd0,
		REG_LATE = 3'd1,
		REG_DISCONT = 3'd2,
		REG_MAX_DEC = 3'd3,
		REG_MAX_POPS = 3'd4,
		REG_PURGE = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_SERVICE = 2'd1,
		OP_REPORT = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ACT_DECODE = 3'd0,
		ACT_LATE = 3'd1,
		ACT_WAITKEY = 3'd2,
		ACT_NOSPS = 3'd3,
		ACT_PURGE = 3'd4,
		ACT_EVICT = 3'd5,
		ACT_NONE = 3'd6
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_EVICT,
		ST_SETUP,
		ST_RD,
		ST_EVAL,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [19:0] lead_ticks;
		logic [23:0] late_ticks;
		logic [25:0] discont_ticks;
		logic [5:0] max_decodes;
		logic [5:0] max_pops;
		logic purge_mode;
	} cfg_t;

	// One descriptor as held in the ring.
	typedef struct packed {
		logic [32:0] pts;
		logic key;
		logic sps;
		logic [15:0] tag;
	} entry_t;

	// Input word data, lowest field in the lowest bits.
	typedef struct packed {
		logic [2:0] pad;
		logic decode_ok;
		logic [15:0] au_tag;
		logic has_sps;
		logic keyframe;
		logic [32:0] clock_req;
		logic [32:0] pts;
	} in_data_t;

	// Output word data, lowest field in the lowest bits.
	typedef struct packed {
		logic [4:0] pad;
		logic [31:0] late_drops;
		logic [31:0] full_drops;
		logic [8:0] queue_count;
		logic entry_key;
		logic [32:0] entry_pts;
		logic [15:0] tag;
	} out_data_t;

	typedef struct packed {
		action_t action;
		logic [15:0] tag;
		logic [32:0] pts;
		logic key;
		logic [8:0] qcount;
		logic [31:0] full_drops;
		logic [31:0] late_drops;
	} res_t;

	// Limits above the per-item maximum are treated as the maximum.
	function automatic logic [5:0] clamp_lim(input logic [5:0] v);
		return (v > MAX_RES) ? MAX_RES : v;
	endfunction

endpackage

>>> hdl/video_au_presentation_queue.sv
// Channel   | Signals                           | Carries
// ----------+-----------------------------------+--------------------------------------------
// s_        | s_tvalid s_tready s_tdata s_tuser | push, service or decode report words
// m_        | m_tvalid m_tready m_tdata m_tuser | action words, m_tlast on the last of an item
// apb       | psel penable pwrite paddr ...     | lead, late, discont, limits, purge mode
//
// A push passes through a write and a closing state, or only the closing one in purge mode where
// nothing is stored; a decode report or unused op passes through the closing state, and a push
// that evicts the oldest entry through an evict state. A service word has a set-up state, then
// an evaluate and a read state per popped entry, since each pop waits on the registered read of
// the new head in the descriptor RAM, and a closing evaluate state that sends the last word.
// Reset clears the queue pointers, flags and counters at once; the RAM is not cleared.
// A stalled output holds its word; the block waits only when a new word must be loaded.
module video_au_presentation_queue #(
	parameter int QUEUE_DEPTH = vapq_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [87:0] s_tdata, // pts, clock_req, keyframe, has_sps, au_tag, decode_ok
	input logic [1:0] s_tuser, // op
	output logic m_tvalid,
	input logic m_tready,
	output logic [127:0] m_tdata, // tag, entry_pts, entry_key, queue_count, full_drops, late_drops
	output logic [2:0] m_tuser, // action
	output logic m_tlast,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	vapq_pkg::cfg_t cfg;
	vapq_pkg::res_t res;
	vapq_pkg::out_data_t odata;
	vapq_pkg::entry_t mem_wdata, mem_rdata;
	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;

	vapq_cfg u_cfg (
		.clk (clk),
		.arst_n (arst_n),
		.psel (psel),
		.penable (penable),
		.pwrite (pwrite),
		.paddr (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg (cfg)
	);

	vapq_store #(.DEPTH(QUEUE_DEPTH)) u_store (
		.clk (clk),
		.we (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	vapq_ctrl #(.DEPTH(QUEUE_DEPTH)) u_ctrl (
		.clk (clk),
		.arst_n (arst_n),
		.cfg (cfg),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op (s_tuser),
		.in_data (vapq_pkg::in_data_t'(s_tdata)),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res (res),
		.out_last (m_tlast),
		.mem_we (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Pack the result into the output word.
	always_comb begin
		odata.pad = '0;
		odata.late_drops = res.late_drops;
		odata.full_drops = res.full_drops;
		odata.queue_count = res.qcount;
		odata.entry_key = res.key;
		odata.entry_pts = res.pts;
		odata.tag = res.tag;
	end

	assign m_tdata = odata;
	assign m_tuser = res.action;

endmodule

>>> hdl/vapq_store.sv
module vapq_store #(
	parameter int DEPTH = vapq_pkg::QUEUE_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input vapq_pkg::entry_t wdata,
	input logic [AW-1:0] raddr,
	output vapq_pkg::entry_t rdata
);

	vapq_pkg::entry_t mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/vapq_cfg.sv
module vapq_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output vapq_pkg::cfg_t cfg
);

	vapq_pkg::cfg_t cfg_q;
	vapq_pkg::reg_idx_t idx;
	logic wr_en;

	assign idx = vapq_pkg::reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	// Register writes; addresses outside the map are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lead_ticks <= vapq_pkg::LEAD_RST;
			cfg_q.late_ticks <= vapq_pkg::LATE_RST;
			cfg_q.discont_ticks <= vapq_pkg::DISCONT_RST;
			cfg_q.max_decodes <= vapq_pkg::MAX_DEC_RST;
			cfg_q.max_pops <= vapq_pkg::MAX_POPS_RST;
			cfg_q.purge_mode <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				vapq_pkg::REG_LEAD: cfg_q.lead_ticks <= pwdata[19:0];
				vapq_pkg::REG_LATE: cfg_q.late_ticks <= pwdata[23:0];
				vapq_pkg::REG_DISCONT: cfg_q.discont_ticks <= pwdata[25:0];
				vapq_pkg::REG_MAX_DEC: cfg_q.max_decodes <= pwdata[5:0];
				vapq_pkg::REG_MAX_POPS: cfg_q.max_pops <= pwdata[5:0];
				vapq_pkg::REG_PURGE: cfg_q.purge_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		prdata = '0;
		case (idx)
			vapq_pkg::REG_LEAD: prdata = {12'd0, cfg_q.lead_ticks};
			vapq_pkg::REG_LATE: prdata = {8'd0, cfg_q.late_ticks};
			vapq_pkg::REG_DISCONT: prdata = {6'd0, cfg_q.discont_ticks};
			vapq_pkg::REG_MAX_DEC: prdata = {26'd0, cfg_q.max_decodes};
			vapq_pkg::REG_MAX_POPS: prdata = {26'd0, cfg_q.max_pops};
			vapq_pkg::REG_PURGE: prdata = {31'd0, cfg_q.purge_mode};
			default: prdata = '0;
		endcase
	end

endmodule

>>> hdl/vapq_ctrl.sv
module vapq_ctrl #(
	parameter int DEPTH = vapq_pkg::QUEUE_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic arst_n,
	input vapq_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] in_op,
	input vapq_pkg::in_data_t in_data,
	output logic out_valid,
	input logic out_ready,
	output vapq_pkg::res_t out_res,
	output logic out_last,
	output logic mem_we,
	output logic [AW-1:0] mem_waddr,
	output vapq_pkg::entry_t mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input vapq_pkg::entry_t mem_rdata
);

	localparam int CW = $clog2(DEPTH + 1);

	// Count masked to the 9-bit result field.
	function automatic logic [8:0] to_q9(input logic [CW-1:0] c);
		logic [CW+8:0] e;
		e = {9'd0, c};
		return e[8:0];
	endfunction

	vapq_pkg::state_t state_q, state_d;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic wait_key_q;
	logic started_q;
	logic [31:0] full_cnt_q;
	logic [31:0] late_cnt_q;

	vapq_pkg::entry_t ent_q;
	logic [32:0] clk_q;
	logic [33:0] due_lim_q;
	logic [33:0] disc_thr_q;
	logic [33:0] late_thr_q;
	logic [5:0] lim_pop_q;
	logic [5:0] lim_dec_q;
	logic [5:0] pops_q;
	logic [5:0] decs_q;

	logic pend_v_q;
	vapq_pkg::res_t pend_q;
	logic out_valid_q;
	vapq_pkg::res_t out_res_q;
	logic out_last_q;

	logic out_free;
	logic accept;
	logic do_write, do_evict, do_setup, do_pop, do_stop;
	logic out_load, out_last_d;
	vapq_pkg::res_t out_res_d;
	vapq_pkg::res_t none_res, pop_res;

	logic [AW-1:0] head_nxt;
	logic [CW:0] tail_sum;
	logic [AW-1:0] tail_idx;
	logic full;

	logic [33:0] p34;
	logic due, disc, late, go;
	vapq_pkg::action_t pop_act;
	logic pop_drop;

	assign in_ready = (state_q == vapq_pkg::ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res = out_res_q;
	assign out_last = out_last_q;
	assign mem_raddr = head_q;

	// Ring index arithmetic.
	assign head_nxt = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign tail_idx = AW'((tail_sum >= (CW+1)'(DEPTH)) ? tail_sum - (CW+1)'(DEPTH) : tail_sum);
	assign full = (count_q == CW'(DEPTH));

	// Classification of the front entry against the registered thresholds.
	assign p34 = {1'b0, mem_rdata.pts};
	assign due = (p34 <= due_lim_q);
	assign disc = !disc_thr_q[33] && (p34 < disc_thr_q);
	assign late = !disc && !late_thr_q[33] && (p34 < late_thr_q);
	assign go = (decs_q < lim_dec_q) && (pops_q < lim_pop_q) && (count_q != '0) && due;

	always_comb begin
		pop_drop = 1'b0;
		if (cfg.purge_mode) begin
			pop_act = vapq_pkg::ACT_PURGE;
		end else if (wait_key_q && !mem_rdata.key) begin
			pop_act = vapq_pkg::ACT_WAITKEY;
			pop_drop = 1'b1;
		end else if (late && !mem_rdata.key) begin
			pop_act = vapq_pkg::ACT_LATE;
			pop_drop = 1'b1;
		end else if (!started_q && !mem_rdata.sps) begin
			pop_act = vapq_pkg::ACT_NOSPS;
		end else begin
			pop_act = vapq_pkg::ACT_DECODE;
		end
	end

	// Result words for a pop and for an item with no action.
	always_comb begin
		pop_res.action = pop_act;
		pop_res.tag = mem_rdata.tag;
		pop_res.pts = mem_rdata.pts;
		pop_res.key = mem_rdata.key;
		pop_res.qcount = to_q9(count_q - 1'b1);
		pop_res.full_drops = full_cnt_q;
		pop_res.late_drops = late_cnt_q + {31'd0, pop_drop};

		none_res.action = vapq_pkg::ACT_NONE;
		none_res.tag = '0;
		none_res.pts = '0;
		none_res.key = 1'b0;
		none_res.qcount = to_q9(count_q);
		none_res.full_drops = full_cnt_q;
		none_res.late_drops = late_cnt_q;
	end

	// Next state and strobes.
	always_comb begin
		state_d = state_q;
		do_write = 1'b0;
		do_evict = 1'b0;
		do_setup = 1'b0;
		do_pop = 1'b0;
		do_stop = 1'b0;
		out_load = 1'b0;
		out_last_d = 1'b0;
		out_res_d = none_res;
		mem_we = 1'b0;
		mem_waddr = tail_idx;
		mem_wdata = ent_q;
		case (state_q)
			vapq_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (vapq_pkg::op_t'(in_op))
						vapq_pkg::OP_PUSH: begin
							if (cfg.purge_mode) begin
								state_d = vapq_pkg::ST_FIN;
							end else if (full) begin
								state_d = vapq_pkg::ST_EVICT;
							end else begin
								state_d = vapq_pkg::ST_WRITE;
							end
						end
						vapq_pkg::OP_SERVICE: state_d = vapq_pkg::ST_SETUP;
						default: state_d = vapq_pkg::ST_FIN;
					endcase
				end
			end
			vapq_pkg::ST_WRITE: begin
				mem_we = 1'b1;
				do_write = 1'b1;
				state_d = vapq_pkg::ST_FIN;
			end
			vapq_pkg::ST_EVICT: begin
				// The oldest slot is reported, then reused for the new entry.
				if (out_free) begin
					mem_we = 1'b1;
					mem_waddr = head_q;
					do_evict = 1'b1;
					out_load = 1'b1;
					out_last_d = 1'b1;
					out_res_d.action = vapq_pkg::ACT_EVICT;
					out_res_d.tag = mem_rdata.tag;
					out_res_d.pts = mem_rdata.pts;
					out_res_d.key = mem_rdata.key;
					out_res_d.qcount = to_q9(CW'(DEPTH - 1));
					out_res_d.full_drops = full_cnt_q + 32'd1;
					out_res_d.late_drops = late_cnt_q;
					state_d = vapq_pkg::ST_IDLE;
				end
			end
			vapq_pkg::ST_SETUP: begin
				do_setup = 1'b1;
				state_d = vapq_pkg::ST_EVAL;
			end
			vapq_pkg::ST_RD: begin
				state_d = vapq_pkg::ST_EVAL;
			end
			vapq_pkg::ST_EVAL: begin
				// A pop's word is held pending until the next pop or the stop, so that its last flag is known.
				if (go) begin
					if (!pend_v_q || out_free) begin
						do_pop = 1'b1;
						out_load = pend_v_q;
						out_res_d = pend_q;
						state_d = vapq_pkg::ST_RD;
					end
				end else if (out_free) begin
					do_stop = 1'b1;
					out_load = 1'b1;
					out_last_d = 1'b1;
					out_res_d = pend_v_q ? pend_q : none_res;
					state_d = vapq_pkg::ST_IDLE;
				end
			end
			vapq_pkg::ST_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					out_last_d = 1'b1;
					state_d = vapq_pkg::ST_IDLE;
				end
			end
			default: state_d = vapq_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vapq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Queue control state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			wait_key_q <= 1'b0;
			started_q <= 1'b0;
			full_cnt_q <= '0;
			late_cnt_q <= '0;
			pops_q <= '0;
			decs_q <= '0;
			pend_v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && (vapq_pkg::op_t'(in_op) == vapq_pkg::OP_REPORT)
				&& in_data.decode_ok && in_data.keyframe) begin
				wait_key_q <= 1'b0;
			end
			if (do_write) begin
				count_q <= count_q + 1'b1;
			end
			if (do_evict) begin
				head_q <= head_nxt;
				full_cnt_q <= full_cnt_q + 32'd1;
			end
			if (do_setup) begin
				pops_q <= '0;
				decs_q <= '0;
			end
			if (do_pop) begin
				head_q <= head_nxt;
				count_q <= count_q - 1'b1;
				pops_q <= pops_q + 1'b1;
				pend_v_q <= 1'b1;
				if (pop_drop) begin
					late_cnt_q <= late_cnt_q + 32'd1;
				end
				if (pop_act == vapq_pkg::ACT_LATE) begin
					wait_key_q <= 1'b1;
				end
				if (pop_act == vapq_pkg::ACT_DECODE) begin
					decs_q <= decs_q + 1'b1;
					started_q <= 1'b1;
				end
			end
			if (do_stop) begin
				pend_v_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q.pts <= in_data.pts;
			ent_q.key <= in_data.keyframe;
			ent_q.sps <= in_data.has_sps;
			ent_q.tag <= in_data.au_tag;
			clk_q <= in_data.clock_req;
		end
		if (do_setup) begin
			due_lim_q <= {1'b0, clk_q} + 34'(cfg.lead_ticks);
			disc_thr_q <= {1'b0, clk_q} - 34'(cfg.discont_ticks);
			late_thr_q <= {1'b0, clk_q} - 34'(cfg.late_ticks);
			lim_pop_q <= vapq_pkg::clamp_lim(cfg.max_pops);
			lim_dec_q <= vapq_pkg::clamp_lim(cfg.max_decodes);
		end
		if (do_pop) begin
			pend_q <= pop_res;
		end
		if (out_load) begin
			out_res_q <= out_res_d;
			out_last_q <= out_last_d;
		end
	end

endmodule

>>> test/vapq_checker.sv
// Watches the input, output and register channels of the presentation queue,
// keeps its own copy of the ring, flags and counters, and compares every
// result word against the oldest outstanding prediction.
module vapq_checker #(
	parameter int DEPTH = vapq_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [87:0] s_tdata, // pts, clock_req, keyframe, has_sps, au_tag, decode_ok
	input logic [1:0] s_tuser, // op
	input logic m_tvalid,
	input logic m_tready,
	input logic [127:0] m_tdata, // tag, entry_pts, entry_key, queue_count, full_drops, late_drops
	input logic [2:0] m_tuser, // action
	input logic m_tlast,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	input logic pready,
	output int fail_count,
	output int pending,
	output int result_count,
	output logic [6:0] acts_seen
);

	import vapq_pkg::*;

	// One predicted result word.
	typedef struct packed {
		action_t act;
		logic [15:0] tag;
		logic [32:0] pts;
		logic key;
		logic last;
		logic [8:0] qcount;
		logic [31:0] full_n;
		logic [31:0] late_n;
	} outcome_t;

	// Shadow copy of the ring and its bookkeeping.
	entry_t ring [DEPTH];
	int head;
	int fill;
	logic wait_key;
	logic dec_started;
	logic [31:0] evict_n;
	logic [31:0] late_n;
	cfg_t cfg;

	outcome_t awaited_actions [$];
	outcome_t batch [32];
	int nb;
	int mism;
	int n_res;
	logic [6:0] seen;

	// Append one result word for the current input word.
	task automatic record(input action_t act, input entry_t e, input logic has);
		outcome_t o;
		o.act = act;
		o.tag = has ? e.tag : 16'h0;
		o.pts = has ? e.pts : 33'h0;
		o.key = has ? e.key : 1'b0;
		o.last = 1'b0;
		o.qcount = 9'(fill);
		o.full_n = evict_n;
		o.late_n = late_n;
		batch[nb] = o;
		nb++;
	endtask

	// Work out the result words that one accepted input word causes.
	task automatic apply_word(input logic [1:0] op, input in_data_t w);
		entry_t e;
		logic [63:0] now;
		logic [63:0] p;
		int lim_pop;
		int lim_dec;
		int pops;
		int decs;
		int i;
		logic discont;
		logic late;
		logic go;
		action_t act;
		nb = 0;
		e = '0;
		case (op)
		OP_PUSH: begin
			// In purge mode nothing is stored at all.
			if (!cfg.purge_mode) begin
				if (fill >= DEPTH) begin
					e = ring[head];
					head = (head + 1) % DEPTH;
					fill = DEPTH - 1;
					evict_n++;
					record(ACT_EVICT, e, 1'b1);
				end
				e.pts = w.pts;
				e.key = w.keyframe;
				e.sps = w.has_sps;
				e.tag = w.au_tag;
				ring[(head + fill) % DEPTH] = e;
				fill++;
			end
		end
		OP_SERVICE: begin
			now = 64'(w.clock_req);
			lim_pop = (cfg.max_pops > MAX_RES) ? int'(MAX_RES) : int'(cfg.max_pops);
			lim_dec = (cfg.max_decodes > MAX_RES) ? int'(MAX_RES) : int'(cfg.max_decodes);
			pops = 0;
			decs = 0;
			go = 1'b1;
			// Pop front entries while they are due and the limits allow.
			while (go && decs < lim_dec && pops < lim_pop && fill > 0) begin
				e = ring[head];
				p = 64'(e.pts);
				if (p > now + 64'(cfg.lead_ticks)) begin
					go = 1'b0;
				end else begin
					head = (head + 1) % DEPTH;
					fill--;
					pops++;
					discont = (p + 64'(cfg.discont_ticks)) < now;
					late = !discont && ((p + 64'(cfg.late_ticks)) < now);
					if (cfg.purge_mode) begin
						act = ACT_PURGE;
					end else if (wait_key && !e.key) begin
						late_n++;
						act = ACT_WAITKEY;
					end else if (late && !e.key) begin
						wait_key = 1'b1;
						late_n++;
						act = ACT_LATE;
					end else if (!dec_started && !e.sps) begin
						act = ACT_NOSPS;
					end else begin
						dec_started = 1'b1;
						decs++;
						act = ACT_DECODE;
					end
					record(act, e, 1'b1);
				end
			end
		end
		OP_REPORT: begin
			// Only a good decode of a keyframe ends the wait for a key.
			if (w.decode_ok && w.keyframe)
				wait_key = 1'b0;
		end
		default: begin
		end
		endcase
		if (nb == 0)
			record(ACT_NONE, e, 1'b0);
		batch[nb - 1].last = 1'b1;
		for (i = 0; i < nb; i++)
			awaited_actions.push_back(batch[i]);
	endtask

	// Report one field that differs from its prediction.
	task automatic check(input string field, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mism++;
		end
	endtask

	// Sample all channels at the clock edge.
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		out_data_t got;
		in_data_t w;
		if (!arst_n) begin
			head = 0;
			fill = 0;
			wait_key = 1'b0;
			dec_started = 1'b0;
			evict_n = '0;
			late_n = '0;
			cfg.lead_ticks = LEAD_RST;
			cfg.late_ticks = LATE_RST;
			cfg.discont_ticks = DISCONT_RST;
			cfg.max_decodes = MAX_DEC_RST;
			cfg.max_pops = MAX_POPS_RST;
			cfg.purge_mode = 1'b0;
			awaited_actions.delete();
			mism = 0;
			n_res = 0;
			seen = '0;
			fail_count <= 0;
			pending <= 0;
			result_count <= 0;
			acts_seen <= '0;
		end else begin
			// Register writes land at the access edge.
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
				REG_LEAD: cfg.lead_ticks = pwdata[19:0];
				REG_LATE: cfg.late_ticks = pwdata[23:0];
				REG_DISCONT: cfg.discont_ticks = pwdata[25:0];
				REG_MAX_DEC: cfg.max_decodes = pwdata[5:0];
				REG_MAX_POPS: cfg.max_pops = pwdata[5:0];
				REG_PURGE: cfg.purge_mode = pwdata[0];
				default: begin
				end
				endcase
			end

			if (s_tvalid && s_tready) begin
				w = s_tdata;
				apply_word(s_tuser, w);
			end

			// Compare each result word with the oldest prediction.
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				n_res++;
				seen[m_tuser] = 1'b1;
				if (awaited_actions.size() == 0) begin
					$error("Result word with no prediction waiting, action %0d", m_tuser);
					mism++;
				end else begin
					want = awaited_actions.pop_front();
					check("action", 64'(want.act), 64'(m_tuser));
					check("tag", 64'(want.tag), 64'(got.tag));
					check("entry_pts", 64'(want.pts), 64'(got.entry_pts));
					check("entry_key", 64'(want.key), 64'(got.entry_key));
					check("last", 64'(want.last), 64'(m_tlast));
					check("queue_count", 64'(want.qcount), 64'(got.queue_count));
					check("full_drops", 64'(want.full_n), 64'(got.full_drops));
					check("late_drops", 64'(want.late_n), 64'(got.late_drops));
				end
			end

			fail_count <= mism;
			pending <= awaited_actions.size();
			result_count <= n_res;
			acts_seen <= seen;
		end
	end

endmodule

>>> test/tb_top.sv
module tb_top;

	import vapq_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int HOLD_CYCLES = 300;
	// Far above the slowest correct run, where every word waits out long stalls.
	localparam int CYCLE_LIMIT = 1500000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [87:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [127:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;
	logic psel;
	logic penable;
	logic pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	int fail_count;
	int pending;
	int result_count;
	logic [6:0] acts_seen;

	logic [32:0] play_clk;
	logic hold_req;
	logic quiet_tx;
	logic quiet_rx;
	int words_sent;
	int settings_used;
	int cycle_n = 0;

	video_au_presentation_queue u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	vapq_checker #(.DEPTH(DEPTH)) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.fail_count(fail_count),
		.pending(pending),
		.result_count(result_count),
		.acts_seen(acts_seen)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if (cycle_n >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	function automatic logic [32:0] rand33();
		return {1'($urandom), $urandom};
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic in_data_t word(input logic [32:0] pts, input logic [32:0] tick,
			input logic key, input logic sps, input logic [15:0] tag, input logic ok);
		in_data_t w;
		w = '0;
		w.pts = pts;
		w.clock_req = tick;
		w.keyframe = key;
		w.has_sps = sps;
		w.au_tag = tag;
		w.decode_ok = ok;
		return w;
	endfunction

	// Offer one word after a random gap and wait until it is taken.
	task automatic send_word(input logic [1:0] op, input in_data_t w);
		int gap;
		gap = quiet_tx ? 0 : pick_gap();
		if ($urandom_range(0, 19) == 0)
			quiet_tx = !quiet_tx;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
	endtask

	// Random word, shaped around a running playback clock so that entries come due.
	task automatic send_random();
		in_data_t w;
		logic [1:0] op;
		int r;
		w = word(rand33(), rand33(), 1'($urandom), 1'($urandom), 16'($urandom), 1'($urandom));
		r = $urandom_range(0, 99);
		if (r < 45) begin
			op = OP_PUSH;
			w.keyframe = ($urandom_range(0, 3) == 0);
			w.has_sps = ($urandom_range(0, 2) == 0);
			if (r >= 2)
				w.pts = play_clk + 33'($urandom_range(0, 8000))
					- 33'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1200000)
					: $urandom_range(0, 60000));
		end else if (r < 80) begin
			op = OP_SERVICE;
			if ($urandom_range(0, 14) == 0)
				play_clk = rand33();
			else
				play_clk = play_clk + 33'($urandom_range(0, 5000));
			w.clock_req = play_clk;
		end else if (r < 92) begin
			op = OP_REPORT;
		end else begin
			op = 2'($urandom_range(0, 3));
		end
		send_word(op, w);
	endtask

	task automatic run_random(input int n);
		int k;
		for (k = 0; k < n; k++)
			send_random();
	endtask

	// Stop offering and wait until every predicted word has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the caller closes the transfer.
	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	task automatic configure(input logic [19:0] lead, input logic [23:0] late,
			input logic [25:0] discont, input logic [5:0] dec, input logic [5:0] pops,
			input logic purge);
		reg_write(REG_LEAD, 32'(lead));
		reg_write(REG_LATE, 32'(late));
		reg_write(REG_DISCONT, 32'(discont));
		reg_write(REG_MAX_DEC, 32'(dec));
		reg_write(REG_MAX_POPS, 32'(pops));
		reg_write(REG_PURGE, 32'(purge));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_used++;
	endtask

	// Output side: random back-pressure, calm stretches and one long hold on request.
	initial begin : sink
		int idle_left;
		int k;
		idle_left = 0;
		quiet_rx = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 149) == 0)
				quiet_rx = !quiet_rx;
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
			end else if (quiet_rx || idle_left == 0) begin
				m_tready <= 1'b1;
				if (!quiet_rx)
					idle_left = pick_gap();
			end else begin
				m_tready <= 1'b0;
				idle_left--;
			end
		end
	end

	initial begin : stimulus
		int i;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_PUSH;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		hold_req = 1'b0;
		quiet_tx = 1'b0;
		play_clk = 33'd10000;
		words_sent = 0;
		settings_used = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset register values.
		send_word(OP_SERVICE, word(33'd0, 33'd0, 1'b0, 1'b0, 16'h0000, 1'b0));
		send_word(OP_REPORT, word(33'd0, 33'd0, 1'b1, 1'b0, 16'h0000, 1'b1));
		send_word(OP_UNUSED, word('1, '1, 1'b1, 1'b1, 16'hFFFF, 1'b1));
		send_word(OP_PUSH, word(33'd0, 33'd0, 1'b0, 1'b0, 16'h0000, 1'b0));
		send_word(OP_PUSH, word(33'd100, 33'd0, 1'b0, 1'b1, 16'hFFFF, 1'b0));
		send_word(OP_PUSH, word(33'd200, 33'd0, 1'b1, 1'b0, 16'h1234, 1'b0));
		send_word(OP_PUSH, word(33'd300, 33'd0, 1'b0, 1'b0, 16'h5678, 1'b0));
		// No SPS yet, then two decodes up to the decode limit.
		send_word(OP_SERVICE, word(33'd0, 33'd0, 1'b0, 1'b0, 16'h0000, 1'b0));
		send_word(OP_PUSH, word(33'd50000, 33'd0, 1'b0, 1'b0, 16'hA001, 1'b0));
		send_word(OP_PUSH, word(33'd60000, 33'd0, 1'b1, 1'b0, 16'hA002, 1'b0));
		// Late drop, wait-for-key drop, then a keyframe decodes regardless.
		send_word(OP_SERVICE, word(33'd0, 33'd100000, 1'b0, 1'b0, 16'h0000, 1'b0));
		send_word(OP_REPORT, word(33'd0, 33'd0, 1'b0, 1'b0, 16'h0000, 1'b1));
		send_word(OP_REPORT, word(33'd0, 33'd0, 1'b1, 1'b0, 16'h0000, 1'b0));
		send_word(OP_REPORT, word(33'd0, 33'd0, 1'b1, 1'b0, 16'h0000, 1'b1));
		// A backward jump past the discontinuity threshold is not late.
		send_word(OP_PUSH, word(33'd0, 33'd0, 1'b0, 1'b0, 16'hA003, 1'b0));
		send_word(OP_SERVICE, word(33'd0, 33'd2000000, 1'b0, 1'b0, 16'h0000, 1'b0));
		send_word(OP_PUSH, word('1, 33'd0, 1'b1, 1'b1, 16'hA004, 1'b0));
		send_word(OP_SERVICE, word(33'd0, '1, 1'b0, 1'b0, 16'h0000, 1'b0));
		// An entry not yet due stays put until the clock reaches it.
		send_word(OP_PUSH, word(33'h1_5555_5555, 33'd0, 1'b0, 1'b1, 16'hA005, 1'b0));
		send_word(OP_SERVICE, word(33'd0, 33'd0, 1'b0, 1'b0, 16'h0000, 1'b0));
		send_word(OP_SERVICE, word(33'd0, '1, 1'b0, 1'b0, 16'h0000, 1'b0));
		drain();

		// Lowest thresholds, with limits of one.
		configure(20'd0, 24'd0, 26'd0, 6'd1, 6'd1, 1'b0);
		run_random(12);
		drain();

		// Highest settings, then stock the ring with due entries.
		configure('1, '1, '1, 6'd32, 6'd32, 1'b0);
		run_random(12);
		for (i = 0; i < 8; i++)
			send_word(OP_PUSH, word(play_clk - 33'(i * 100), rand33(), 1'($urandom),
				1'($urandom), 16'($urandom), 1'($urandom)));
		drain();

		// Purge mode: pushes are ignored, every pop is purged.
		configure(LEAD_RST, LATE_RST, DISCONT_RST, 6'd32, 6'd32, 1'b1);
		send_word(OP_SERVICE, word(rand33(), play_clk, 1'b0, 1'b0, 16'h0000, 1'b0));
		run_random(15);
		drain();

		// A decode limit of zero, with the pop limit above its maximum.
		configure(20'd1000, 24'd30000, 26'd600000, 6'd0, 6'd0, 1'b0);
		configure(20'd1000, 24'd30000, 26'd600000, 6'd0, 6'd63, 1'b0);
		run_random(10);
		drain();

		// A pop limit of zero.
		configure(20'd1000, 24'd30000, 26'd600000, 6'd63, 6'd0, 1'b0);
		run_random(5);
		drain();

		// Long output hold while the sender keeps offering pushes.
		configure(20'd5000, 24'd20000, 26'd400000, 6'd63, 6'd5, 1'b0);
		hold_req = 1'b1;
		quiet_tx = 1'b1;
		for (i = 0; i < 12; i++)
			send_word(OP_PUSH, word(play_clk + 33'(i * 40), rand33(), 1'($urandom),
				1'($urandom), 16'($urandom), 1'($urandom)));
		run_random(10);
		drain();

		$display("Run covered %0d input words under %0d register settings: purge mode,",
			words_sent, settings_used);
		$display("zero and oversized limits, a long output hold; %0d results, actions seen %b.",
			result_count, acts_seen);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

>>> filelist.f
hdl/vapq_pkg.sv
hdl/vapq_store.sv
hdl/vapq_cfg.sv
hdl/vapq_ctrl.sv
hdl/video_au_presentation_queue.sv
test/vapq_checker.sv
test/tb_top.sv
